// File: rtl/ssd_pkg.sv
// ============================================================================
// ssd_pkg : shared types and constants of the stair step detector
// Sample, result, configuration and datapath command types, widths, register
// map and reset values used by every module of the detector.
// ============================================================================
package ssd_pkg;

    // Field widths.
    localparam int SAMPLE_BITS   = 16;
    localparam int COUNT_BITS    = 16;
    localparam int TIME_BITS     = 32;
    localparam int GAIN_BITS     = 16;
    localparam int THR_BITS      = 15;
    localparam int INTERVAL_BITS = 16;

    // The average carries eight fraction bits below the unsigned Q4.12 magnitude.
    localparam int FRAC_EXT  = 8;
    localparam int AVG_BITS  = SAMPLE_BITS + FRAC_EXT;
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int PROD_BITS = AVG_BITS + GAIN_BITS;

    // Configuration port.
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    localparam logic [2:0] REG_AVG_GAIN        = 3'd0;
    localparam logic [2:0] REG_PEAK_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_MIN_INTERVAL_MS = 3'd2;
    localparam logic [2:0] REG_DOWN_THRESHOLD  = 3'd3;
    localparam logic [2:0] REG_UP_THRESHOLD    = 3'd4;
    localparam logic [2:0] REG_QUIET_THRESHOLD = 3'd5;

    localparam logic [GAIN_BITS-1:0]     RST_AVG_GAIN        = 16'd9830;
    localparam logic [THR_BITS-1:0]      RST_PEAK_THRESHOLD  = 15'd614;
    localparam logic [INTERVAL_BITS-1:0] RST_MIN_INTERVAL_MS = 16'd450;
    localparam logic [THR_BITS-1:0]      RST_DOWN_THRESHOLD  = 15'd492;
    localparam logic [THR_BITS-1:0]      RST_UP_THRESHOLD    = 15'd328;
    localparam logic [THR_BITS-1:0]      RST_QUIET_THRESHOLD = 15'd205;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic [TIME_BITS-1:0]          time_ms;
    } sample_t;

    typedef struct packed {
        logic                  step_up;
        logic                  step_down;
        logic [COUNT_BITS-1:0] up_count;
        logic [COUNT_BITS-1:0] down_count;
        logic [COUNT_BITS-1:0] total_count;
    } result_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0]     avg_gain;
        logic [THR_BITS-1:0]      peak_threshold;
        logic [INTERVAL_BITS-1:0] min_interval_ms;
        logic [THR_BITS-1:0]      down_threshold;
        logic [THR_BITS-1:0]      up_threshold;
        logic [THR_BITS-1:0]      quiet_threshold;
    } cfg_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic  load;
        logic  square;
        axis_t sq_axis;
        logic  root_step;
        logic  scale;
        logic  update;
        logic  commit;
    } dp_cmd_t;

    typedef struct packed {
        logic root_last;
    } dp_status_t;

endpackage

// File: rtl/stair_step_detector_core.sv
// ============================================================================
// stair_step_detector_core : accelerometer stair step detector
// Forms the magnitude of each three-axis sample, tracks its exponential
// average and counts steps up and down from peaks of the deviation.
// ============================================================================
//
//  Channel  Dir  Handshake                   Payload
//  -------  ---  --------------------------  ------------------------------
//  sample   in   sample_valid / sample_stall  sample_t: accel_x/y/z, time_ms
//  result   out  result_valid / result_stall  result_t: step flags, counts
//  config   in   APB psel/penable/pwrite      six settings, read back
//
// A sample transfer is taken in the idle cycle; the datapath then squares the
// axes in turn on one shared multiplier, works out the square root (one
// result bit per cycle, which sets the rate), and then does the average
// multiply, average update and step decision. No new sample is taken until
// the pass is through. The result register sits between the two sides, so
// a waiting result does not block the next sample; only the decision cycle waits
// while a previous result is still stalled. Reset clears the detector state,
// the counters and the result valid flag, and loads the default settings.
//
module stair_step_detector_core
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Sample channel.
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    // Result channel.
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Every access completes in its access cycle.
    assign pready = 1'b1;

    ssd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The sequencer issues one command per cycle and watches the root counter.
    ssd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    ssd_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// File: rtl/ssd_regs.sv
// ============================================================================
// ssd_regs : configuration register file
// Six detector settings behind an APB-style port, with read back.
// ============================================================================
module ssd_regs
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] index;

    assign wr_en = psel & penable & pwrite;
    assign index = paddr[4:2];
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avg_gain        <= RST_AVG_GAIN;
            cfg_reg.peak_threshold  <= RST_PEAK_THRESHOLD;
            cfg_reg.min_interval_ms <= RST_MIN_INTERVAL_MS;
            cfg_reg.down_threshold  <= RST_DOWN_THRESHOLD;
            cfg_reg.up_threshold    <= RST_UP_THRESHOLD;
            cfg_reg.quiet_threshold <= RST_QUIET_THRESHOLD;
        end
        else if (wr_en)
        begin
            case (index)
                REG_AVG_GAIN:        cfg_reg.avg_gain        <= pwdata[GAIN_BITS-1:0];
                REG_PEAK_THRESHOLD:  cfg_reg.peak_threshold  <= pwdata[THR_BITS-1:0];
                REG_MIN_INTERVAL_MS: cfg_reg.min_interval_ms <= pwdata[INTERVAL_BITS-1:0];
                REG_DOWN_THRESHOLD:  cfg_reg.down_threshold  <= pwdata[THR_BITS-1:0];
                REG_UP_THRESHOLD:    cfg_reg.up_threshold    <= pwdata[THR_BITS-1:0];
                REG_QUIET_THRESHOLD: cfg_reg.quiet_threshold <= pwdata[THR_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_AVG_GAIN:
                prdata = DATA_BITS'(cfg_reg.avg_gain);
            REG_PEAK_THRESHOLD:
                prdata = DATA_BITS'(cfg_reg.peak_threshold);
            REG_MIN_INTERVAL_MS:
                prdata = DATA_BITS'(cfg_reg.min_interval_ms);
            REG_DOWN_THRESHOLD:
                prdata = DATA_BITS'(cfg_reg.down_threshold);
            REG_UP_THRESHOLD:
                prdata = DATA_BITS'(cfg_reg.up_threshold);
            REG_QUIET_THRESHOLD:
                prdata = DATA_BITS'(cfg_reg.quiet_threshold);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: rtl/ssd_ctrl.sv
// ============================================================================
// ssd_ctrl : detector sequencer
// Steps the datapath through squaring, square root, average update and the
// step decision, and owns the result valid flag.
// ============================================================================
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    output logic       result_valid,
    input  logic       result_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_SCALE,
        ST_UPDATE,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;
    axis_t  axis_reg, axis_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    // The result register can take a new transfer when empty or being drained.
    assign out_free     = !valid_reg || !result_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        valid_next = valid_reg && result_stall;
        cmd        = '0;
        cmd.sq_axis = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = AXIS_X;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                case (axis_reg)
                    AXIS_X:  axis_next = AXIS_Y;
                    AXIS_Y:  axis_next = AXIS_Z;
                    default: state_next = ST_ROOT;
                endcase
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= AXIS_X;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: rtl/ssd_dp.sv
// ============================================================================
// ssd_dp : detector datapath
// Shared squarer, bit-per-cycle square root, average multiplier, detector
// state, step counters and the result register.
// ============================================================================
module ssd_dp
    import ssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sample_t    sample,
    input  cfg_t       cfg,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output result_t    result
);

    // Captured sample.
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg, z_reg;
    logic [TIME_BITS-1:0]          now_reg;

    // Square-root working registers.
    logic [SQ_BITS-1:0] rem_reg, rem_next;
    logic [SQ_BITS-1:0] res_reg, res_next;
    logic [SQ_BITS-1:0] bit_reg, bit_next;

    // Average update.
    logic [PROD_BITS-1:0] prod_reg;
    logic                 neg_reg;

    // Detector state.
    logic [AVG_BITS-1:0]           avg_reg, avg_next;
    logic signed [SAMPLE_BITS-1:0] zref_reg, zref_next;
    logic                          wait_reg, wait_next;
    logic [TIME_BITS-1:0]          last_reg, last_next;
    logic                          seeded_reg, seeded_next;
    logic [COUNT_BITS-1:0]         up_cnt_reg, up_cnt_next;
    logic [COUNT_BITS-1:0]         down_cnt_reg, down_cnt_next;
    logic [COUNT_BITS-1:0]         all_cnt_reg, all_cnt_next;
    result_t                       result_reg, result_next;

    logic signed [SAMPLE_BITS-1:0] sq_op;
    logic signed [SQ_BITS-1:0]     sq;
    logic [SQ_BITS:0]              trial;
    logic [AVG_BITS-1:0]           mag_ext;
    logic signed [AVG_BITS:0]      diff;
    logic signed [AVG_BITS:0]      abs_full;
    logic [AVG_BITS-1:0]           delta;
    logic signed [AVG_BITS:0]      dm;
    logic signed [AVG_BITS:0]      peak_ext, quiet_ext;
    logic signed [SAMPLE_BITS:0]   dz, down_lim, up_lim;
    logic [TIME_BITS-1:0]          elapsed;
    logic                          fire, go_down, go_up;

    assign status.root_last = bit_reg[0];
    assign result           = result_reg;

    always_comb
    begin
        case (cmd.sq_axis)
            AXIS_X:  sq_op = x_reg;
            AXIS_Y:  sq_op = y_reg;
            default: sq_op = z_reg;
        endcase
    end

    assign sq    = sq_op * sq_op;
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (cmd.load)
        begin
            rem_next = '0;
            res_next = '0;
            bit_next = SQ_BITS'(1) << (SQ_BITS - 2);
        end
        else if (cmd.square)
        begin
            rem_next = rem_reg + $unsigned(sq);
        end
        else if (cmd.root_step)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[SQ_BITS-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    // Magnitude with the extra average fraction bits.
    assign mag_ext  = {res_reg[SAMPLE_BITS-1:0], {FRAC_EXT{1'b0}}};
    assign diff     = $signed({1'b0, mag_ext}) - $signed({1'b0, avg_reg});
    assign abs_full = diff[AVG_BITS] ? -diff : diff;
    assign delta    = prod_reg[PROD_BITS-1:GAIN_BITS];

    // Deviation from the freshly updated average.
    assign dm = $signed({1'b0, mag_ext}) - $signed({1'b0, avg_reg});
    assign peak_ext  = $signed({{(AVG_BITS + 1 - THR_BITS - FRAC_EXT){1'b0}},
                                cfg.peak_threshold, {FRAC_EXT{1'b0}}});
    assign quiet_ext = $signed({{(AVG_BITS + 1 - THR_BITS - FRAC_EXT){1'b0}},
                                cfg.quiet_threshold, {FRAC_EXT{1'b0}}});

    assign dz = $signed({z_reg[SAMPLE_BITS-1], z_reg})
              - $signed({zref_reg[SAMPLE_BITS-1], zref_reg});
    assign down_lim = -$signed({{(SAMPLE_BITS + 1 - THR_BITS){1'b0}}, cfg.down_threshold});
    assign up_lim   = $signed({{(SAMPLE_BITS + 1 - THR_BITS){1'b0}}, cfg.up_threshold});
    assign elapsed  = now_reg - last_reg;

    assign fire = !wait_reg && (dm > peak_ext)
               && (elapsed > TIME_BITS'(cfg.min_interval_ms));
    assign go_down = fire && (dz < down_lim);
    assign go_up   = fire && !go_down && (dz > up_lim);

    always_comb
    begin
        avg_next      = avg_reg;
        zref_next     = zref_reg;
        wait_next     = wait_reg;
        last_next     = last_reg;
        seeded_next   = seeded_reg;
        up_cnt_next   = up_cnt_reg;
        down_cnt_next = down_cnt_reg;
        all_cnt_next  = all_cnt_reg;
        result_next   = result_reg;

        if (cmd.update)
        begin
            if (!seeded_reg)
            begin
                avg_next = mag_ext;
            end
            else if (neg_reg)
            begin
                avg_next = avg_reg - delta;
            end
            else
            begin
                avg_next = avg_reg + delta;
            end
        end

        if (cmd.commit)
        begin
            if (!seeded_reg)
            begin
                zref_next   = z_reg;
                last_next   = now_reg;
                seeded_next = 1'b1;
            end
            else
            begin
                if (go_down && !(&down_cnt_reg))
                begin
                    down_cnt_next = down_cnt_reg + 1'b1;
                end
                if (go_up && !(&up_cnt_reg))
                begin
                    up_cnt_next = up_cnt_reg + 1'b1;
                end
                if (go_up || go_down)
                begin
                    if (!(&all_cnt_reg))
                    begin
                        all_cnt_next = all_cnt_reg + 1'b1;
                    end
                    last_next = now_reg;
                    wait_next = 1'b1;
                end
                else if (wait_reg && (dm < quiet_ext))
                begin
                    wait_next = 1'b0;
                end
                if ((dm < quiet_ext) && (dm > -quiet_ext))
                begin
                    zref_next = z_reg;
                end
            end
            result_next.step_up     = seeded_reg && go_up;
            result_next.step_down   = seeded_reg && go_down;
            result_next.up_count    = up_cnt_next;
            result_next.down_count  = down_cnt_next;
            result_next.total_count = all_cnt_next;
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample.accel_x;
            y_reg   <= sample.accel_y;
            z_reg   <= sample.accel_z;
            now_reg <= sample.time_ms;
        end
        if (cmd.scale)
        begin
            neg_reg  <= diff[AVG_BITS];
            prod_reg <= abs_full[AVG_BITS-1:0] * cfg.avg_gain;
        end
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg      <= '0;
            zref_reg     <= '0;
            wait_reg     <= 1'b0;
            last_reg     <= '0;
            seeded_reg   <= 1'b0;
            up_cnt_reg   <= '0;
            down_cnt_reg <= '0;
            all_cnt_reg  <= '0;
        end
        else
        begin
            avg_reg      <= avg_next;
            zref_reg     <= zref_next;
            wait_reg     <= wait_next;
            last_reg     <= last_next;
            seeded_reg   <= seeded_next;
            up_cnt_reg   <= up_cnt_next;
            down_cnt_reg <= down_cnt_next;
            all_cnt_reg  <= all_cnt_next;
        end
    end

endmodule

// File: tb/stair_step_detector_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// stair_step_detector_core_test : self-checking bench for the step detector
// Drives accelerometer samples through the valid/stall sample channel while
// the APB port moves the detector through default, extreme and random
// settings. A behavioral model in the bench predicts every result transfer,
// and each one is compared field by field.
// ============================================================================
module stair_step_detector_core_test;
    import ssd_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int MAX_IDLE      = 8;
    localparam int SETTLE_CYCLES = 40;      // longer than one sample pass
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;

    // Indexes just past the register map; writes there must be ignored.
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    sample_t              sample;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    stair_step_detector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench model of the detector. These variables mirror the settings and
    // the detector state as they stand after every accepted sample.
    // ------------------------------------------------------------------------
    cfg_t                         active_cfg;
    logic [AVG_BITS-1:0]          mag_average;
    logic signed [SAMPLE_BITS-1:0] quiet_z;
    logic                         disarmed;
    logic [TIME_BITS-1:0]         last_step_time;
    logic                         primed;
    logic [COUNT_BITS-1:0]        up_tally;
    logic [COUNT_BITS-1:0]        down_tally;
    logic [COUNT_BITS-1:0]        step_tally;

    // Reports still owed by the block, oldest first.
    result_t expected_steps[$];

    int unsigned cycle_count = 0;
    int          failures = 0;
    int          samples_sent = 0;
    int          reports_checked = 0;
    int          settings_applied = 0;
    int          sender_gap_max = MAX_IDLE;
    int          receiver_stall_max = MAX_IDLE;
    logic [TIME_BITS-1:0] now_ms;
    int          rest_z = 4096;

    // Floor of the square root, found one result bit at a time from the top.
    function automatic longint floor_sqrt(longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = SAMPLE_BITS - 1; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // Advances the model by one sample and returns the report it must produce.
    function automatic result_t detect_steps(sample_t s);
        longint x;
        longint y;
        longint z;
        longint mag;
        longint avg;
        longint diff;
        longint dm;
        longint quiet;
        longint dz;
        logic [TIME_BITS-1:0] elapsed;
        result_t r;
        x = longint'($signed(s.accel_x));
        y = longint'($signed(s.accel_y));
        z = longint'($signed(s.accel_z));
        mag = floor_sqrt(x * x + y * y + z * z) << FRAC_EXT;
        r = '0;
        if (!primed)
        begin
            // The first sample only seeds the average, the z level and the clock.
            mag_average = mag[AVG_BITS-1:0];
            quiet_z = s.accel_z;
            last_step_time = s.time_ms;
            primed = 1'b1;
        end
        else
        begin
            avg = longint'(mag_average);
            diff = mag - avg;
            if (diff >= 0)
                avg = avg + ((diff * longint'(active_cfg.avg_gain)) >> GAIN_BITS);
            else
                avg = avg - (((-diff) * longint'(active_cfg.avg_gain)) >> GAIN_BITS);
            mag_average = avg[AVG_BITS-1:0];
            dm = mag - avg;
            quiet = longint'(active_cfg.quiet_threshold) << FRAC_EXT;
            if (!disarmed)
            begin
                elapsed = s.time_ms - last_step_time;
                if (dm > (longint'(active_cfg.peak_threshold) << FRAC_EXT) &&
                    elapsed > TIME_BITS'(active_cfg.min_interval_ms))
                begin
                    dz = z - longint'(quiet_z);
                    if (dz < -longint'(active_cfg.down_threshold))
                    begin
                        r.step_down = 1'b1;
                        if (down_tally != '1)
                            down_tally++;
                    end
                    else if (dz > longint'(active_cfg.up_threshold))
                    begin
                        r.step_up = 1'b1;
                        if (up_tally != '1)
                            up_tally++;
                    end
                    if (r.step_up || r.step_down)
                    begin
                        if (step_tally != '1)
                            step_tally++;
                        last_step_time = s.time_ms;
                        disarmed = 1'b1;
                    end
                end
            end
            else if (dm < quiet)
            begin
                disarmed = 1'b0;
            end
            if (dm < quiet && dm > -quiet)
                quiet_z = s.accel_z;
        end
        r.up_count = up_tally;
        r.down_count = down_tally;
        r.total_count = step_tally;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers.
    // ------------------------------------------------------------------------
    task automatic note_failure(string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endtask

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic sample_t make_sample(int x, int y, int z, logic [TIME_BITS-1:0] t);
        sample_t s;
        s.accel_x = SAMPLE_BITS'(x);
        s.accel_y = SAMPLE_BITS'(y);
        s.accel_z = SAMPLE_BITS'(z);
        s.time_ms = t;
        return s;
    endfunction

    // Offers one sample after a random gap and holds it until the block takes
    // the transfer. Valid is left high afterwards, so a following sample with
    // no gap goes out back to back without valid being touched twice.
    task automatic send_sample(sample_t s);
        int gap;
        gap = $urandom_range(sender_gap_max);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        expected_steps.push_back(detect_steps(s));
        samples_sent++;
    endtask

    // A settled sample near one g with a little sensor noise.
    task automatic send_rest(int dt);
        now_ms = now_ms + TIME_BITS'(dt);
        send_sample(make_sample(rand_between(-30, 30), rand_between(-30, 30),
                                rest_z + rand_between(-30, 30), now_ms));
    endtask

    // A foot strike: a sideways kick that raises the magnitude, with a shift in z.
    task automatic send_jolt(int dt, int dx, int dz);
        now_ms = now_ms + TIME_BITS'(dt);
        send_sample(make_sample(dx, rand_between(-1500, 1500), rest_z + dz, now_ms));
    endtask

    task automatic send_noise();
        send_sample(make_sample(int'($urandom), int'($urandom), int'($urandom), $urandom));
    endtask

    // One stride: a few quiet samples followed by a strike with random shape.
    // Now and then the quiet part is skipped or a garbage sample follows, so
    // the detector also sees strikes while still disarmed and broken rhythm.
    task automatic send_stride();
        int rests;
        int dx;
        int dz;
        rests = rand_between(1, 4);
        if ($urandom_range(9) == 0)
            rests = 0;
        repeat (rests) send_rest(rand_between(5, 80));
        dx = rand_between(1500, 6000) * (($urandom_range(1) == 1) ? 1 : -1);
        dz = rand_between(100, 2500) * (($urandom_range(1) == 1) ? 1 : -1);
        send_jolt(rand_between(10, 300), dx, dz);
        if ($urandom_range(9) == 0)
            send_noise();
    endtask

    // Drops valid and waits until every owed report has come back, then lets
    // the block run out its pass before the settings are touched.
    task automatic wait_idle();
        int waited;
        waited = 0;
        sample_valid <= 1'b0;
        while (expected_steps.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup cycle, access cycle, then an idle cycle so that
    // back-to-back calls never drive psel twice in one step.
    task automatic write_register(logic [2:0] idx, logic [DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_AVG_GAIN:        active_cfg.avg_gain = value[GAIN_BITS-1:0];
            REG_PEAK_THRESHOLD:  active_cfg.peak_threshold = value[THR_BITS-1:0];
            REG_MIN_INTERVAL_MS: active_cfg.min_interval_ms = value[INTERVAL_BITS-1:0];
            REG_DOWN_THRESHOLD:  active_cfg.down_threshold = value[THR_BITS-1:0];
            REG_UP_THRESHOLD:    active_cfg.up_threshold = value[THR_BITS-1:0];
            REG_QUIET_THRESHOLD: active_cfg.quiet_threshold = value[THR_BITS-1:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Reads every setting back and compares it with the bench's copy. The
    // read data is taken in the middle of the access cycle.
    task automatic check_registers();
        logic [DATA_BITS-1:0] want;
        logic [DATA_BITS-1:0] got;
        for (int r = REG_AVG_GAIN; r <= REG_QUIET_THRESHOLD; r++)
        begin
            case (3'(r))
                REG_AVG_GAIN:        want = DATA_BITS'(active_cfg.avg_gain);
                REG_PEAK_THRESHOLD:  want = DATA_BITS'(active_cfg.peak_threshold);
                REG_MIN_INTERVAL_MS: want = DATA_BITS'(active_cfg.min_interval_ms);
                REG_DOWN_THRESHOLD:  want = DATA_BITS'(active_cfg.down_threshold);
                REG_UP_THRESHOLD:    want = DATA_BITS'(active_cfg.up_threshold);
                default:             want = DATA_BITS'(active_cfg.quiet_threshold);
            endcase
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {3'(r), 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(negedge clk);
            got = prdata;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            if (got !== want)
                note_failure($sformatf("register %0d reads 0x%08h, expected 0x%08h",
                                       r, got, want));
        end
    endtask

    task automatic apply_settings(cfg_t c);
        wait_idle();
        write_register(REG_AVG_GAIN, DATA_BITS'(c.avg_gain));
        write_register(REG_PEAK_THRESHOLD, DATA_BITS'(c.peak_threshold));
        write_register(REG_MIN_INTERVAL_MS, DATA_BITS'(c.min_interval_ms));
        write_register(REG_DOWN_THRESHOLD, DATA_BITS'(c.down_threshold));
        write_register(REG_UP_THRESHOLD, DATA_BITS'(c.up_threshold));
        write_register(REG_QUIET_THRESHOLD, DATA_BITS'(c.quiet_threshold));
        check_registers();
        settings_applied++;
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Hand-built walk under the reset settings. It seeds just before the
    // timestamp wraps, shows a peak with too little z change, a step down,
    // a strike too soon after a step, a strike exactly at the minimum
    // interval (not counted), a step up, and then the extremes of the axes
    // and of the timestamp.
    task automatic test_directed_steps();
        int dt;
        check_registers();
        sender_gap_max = MAX_IDLE;
        receiver_stall_max = MAX_IDLE;
        rest_z = 4096;
        now_ms = 32'hFFFF_FE00;
        send_rest(0);
        repeat (3) send_rest(20);
        send_jolt(600, 4500, 50);
        repeat (4) send_rest(20);
        send_jolt(30, 4500, -800);
        repeat (3) send_rest(20);
        send_jolt(20, 0, 1500);
        repeat (4) send_rest(20);
        dt = int'(last_step_time + TIME_BITS'(active_cfg.min_interval_ms) - now_ms);
        send_jolt(dt, 0, 1500);
        repeat (3) send_rest(20);
        send_jolt(100, 0, 1500);
        send_rest(20);
        send_sample(make_sample(-32768, -32768, -32768, 32'h0000_0000));
        send_sample(make_sample(32767, 32767, 32767, 32'hFFFF_FFFF));
        send_sample(make_sample(0, 0, 0, now_ms));
    endtask

    // Every setting is written with all data bits set, so the bench sees the
    // masking to each register's width, then addresses past the map are
    // written and must change nothing. A short walk follows on sane values.
    task automatic test_register_access();
        cfg_t c;
        int start;
        wait_idle();
        for (int r = REG_AVG_GAIN; r <= REG_QUIET_THRESHOLD; r++)
            write_register(3'(r), 32'hFFFF_FFFF);
        check_registers();
        write_register(REG_UNUSED_LO, $urandom);
        write_register(REG_UNUSED_HI, 32'hFFFF_FFFF);
        check_registers();
        c = '{16'($urandom_range(3000, 20000)), 15'(rand_between(300, 900)),
              16'(rand_between(50, 500)), 15'(rand_between(200, 800)),
              15'(rand_between(200, 800)), 15'(rand_between(100, 400))};
        apply_settings(c);
        start = samples_sent;
        while (samples_sent - start < 40)
            send_stride();
    endtask

    // Long random walk on the reset settings, seeded near the top of the
    // timestamp range so the clock wraps part way through. The last 100 of
    // the 300 samples run with no idling on either side.
    task automatic test_random_walk();
        int start;
        cfg_t c;
        c = '{RST_AVG_GAIN, RST_PEAK_THRESHOLD, RST_MIN_INTERVAL_MS,
              RST_DOWN_THRESHOLD, RST_UP_THRESHOLD, RST_QUIET_THRESHOLD};
        apply_settings(c);
        rest_z = rand_between(3600, 4600);
        now_ms = 32'hFFFF_F000;
        start = samples_sent;
        while (samples_sent - start < 300)
        begin
            if (samples_sent - start >= 200)
            begin
                sender_gap_max = 0;
                receiver_stall_max = 0;
            end
            send_stride();
        end
        sender_gap_max = MAX_IDLE;
        receiver_stall_max = MAX_IDLE;
    endtask

    // Several settings, the extremes first: all zero, all full scale, a
    // fast tracking average that can never call a sample quiet, a frozen
    // average, then random ones. Idling is switched off on every other one.
    task automatic test_setting_sweep();
        cfg_t c;
        int start;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: c = '{16'd0, 15'd0, 16'd0, 15'd0, 15'd0, 15'd0};
                1: c = '{16'hFFFF, 15'h7FFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
                2: c = '{16'hFFFF, 15'd0, 16'd0, 15'd0, 15'd0, 15'd0};
                3: c = '{16'd0, 15'd300, 16'd0, 15'd200, 15'd200, 15'h7FFF};
                default: c = '{16'($urandom), 15'(rand_between(200, 1500)),
                               16'(rand_between(0, 600)), 15'(rand_between(100, 1500)),
                               15'(rand_between(100, 1500)), 15'(rand_between(50, 800))};
            endcase
            apply_settings(c);
            sender_gap_max = (phase % 2 == 1) ? 0 : MAX_IDLE;
            receiver_stall_max = (phase % 2 == 1) ? 0 : MAX_IDLE;
            rest_z = rand_between(3600, 4600);
            start = samples_sent;
            while (samples_sent - start < 50)
                send_stride();
        end
        sender_gap_max = MAX_IDLE;
        receiver_stall_max = MAX_IDLE;
    endtask

    // Fully random samples, every bit of every field free, on random settings.
    task automatic test_random_samples();
        cfg_t c;
        c = '{16'($urandom), 15'($urandom), 16'($urandom), 15'($urandom),
              15'($urandom), 15'($urandom)};
        apply_settings(c);
        repeat (80) send_noise();
    endtask

    // ------------------------------------------------------------------------
    // Result side. For each report the receiver stalls for a random number
    // of cycles, then takes the next transfer and compares it against the
    // oldest expectation. Payload and valid are read just after the clock
    // edge, which still shows the values that the edge sampled.
    // ------------------------------------------------------------------------
    initial
    begin
        int      stall_len;
        result_t want;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall_len = $urandom_range(receiver_stall_max);
            if (stall_len > 0)
            begin
                result_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            if (expected_steps.size() == 0)
            begin
                note_failure($sformatf("report with no sample owing it: up=%0d down=%0d",
                                       result.step_up, result.step_down));
            end
            else
            begin
                want = expected_steps.pop_front();
                reports_checked++;
                if (result.step_up !== want.step_up ||
                    result.step_down !== want.step_down ||
                    result.up_count !== want.up_count ||
                    result.down_count !== want.down_count ||
                    result.total_count !== want.total_count)
                    note_failure($sformatf(
                        "report %0d: expected up=%0d down=%0d counts %0d/%0d/%0d, got up=%0d down=%0d counts %0d/%0d/%0d",
                        reports_checked, want.step_up, want.step_down, want.up_count,
                        want.down_count, want.total_count, result.step_up,
                        result.step_down, result.up_count, result.down_count,
                        result.total_count));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d reports still owed.",
                     cycle_count, expected_steps.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        active_cfg = '{RST_AVG_GAIN, RST_PEAK_THRESHOLD, RST_MIN_INTERVAL_MS,
                       RST_DOWN_THRESHOLD, RST_UP_THRESHOLD, RST_QUIET_THRESHOLD};
        mag_average = '0;
        quiet_z = '0;
        disarmed = 1'b0;
        last_step_time = '0;
        primed = 1'b0;
        up_tally = '0;
        down_tally = '0;
        step_tally = '0;
        now_ms = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_steps();
        test_register_access();
        test_random_walk();
        test_setting_sweep();
        test_random_samples();

        wait_idle();
        if (expected_steps.size() != 0)
            note_failure($sformatf("%0d reports never arrived", expected_steps.size()));

        $display("Checked %0d step reports from %0d samples over %0d register settings;",
                 reports_checked, samples_sent, settings_applied);
        $display("the model counted %0d steps up and %0d steps down, %0d failures.",
                 up_tally, down_tally, failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: stair_step_detector_core.f
rtl/ssd_pkg.sv
rtl/ssd_regs.sv
rtl/ssd_ctrl.sv
rtl/ssd_dp.sv
rtl/stair_step_detector_core.sv
tb/stair_step_detector_core_test.sv
